/* rtl/core/rtc3w_pkg.sv */
package rtc3w_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int HALF_W        = 16;

	// command codes
	localparam logic [2:0] CMD_NONE        = 3'd0;
	localparam logic [2:0] CMD_READ_REG    = 3'd1;
	localparam logic [2:0] CMD_WRITE_REG   = 3'd2;
	localparam logic [2:0] CMD_READ_RAM    = 3'd3;
	localparam logic [2:0] CMD_WRITE_RAM   = 3'd4;
	localparam logic [2:0] CMD_BURST_READ  = 3'd5;
	localparam logic [2:0] CMD_BURST_WRITE = 3'd6;

	// command byte templates
	localparam logic [7:0] ADDR_MASK         = 8'h1f;
	localparam logic [7:0] CB_READ_REG       = 8'h81;
	localparam logic [7:0] CB_WRITE_REG      = 8'h80;
	localparam logic [7:0] CB_READ_RAM       = 8'hc1;
	localparam logic [7:0] CB_WRITE_RAM      = 8'hc0;
	localparam logic [7:0] CB_BURST_READ     = 8'hbf;
	localparam logic [7:0] CB_BURST_WRITE    = 8'hbe;

	// sequencer phases
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_SETUP  = 4'd1;
	localparam logic [3:0] PH_CMD_HI = 4'd2;
	localparam logic [3:0] PH_CMD_LO = 4'd3;
	localparam logic [3:0] PH_WR_HI  = 4'd4;
	localparam logic [3:0] PH_WR_LO  = 4'd5;
	localparam logic [3:0] PH_TURN   = 4'd6;
	localparam logic [3:0] PH_RD_HI  = 4'd7;
	localparam logic [3:0] PH_RD_LO  = 4'd8;
	localparam logic [3:0] PH_HOLD   = 4'd9;
	localparam logic [3:0] PH_DONE   = 4'd10;

	localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

	typedef struct packed {
		logic [2:0] command;
		logic [4:0] address;
		logic [7:0] write_data;
		logic [4:0] burst_length;
		logic       data_pin;
	} item_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_out;
		logic       data_drive;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       write_taken;
		logic       busy_res;
		logic       done_res;
	} result_t;

	typedef struct packed {
		logic [3:0]        phase;
		logic [HALF_W-1:0] tick_count;
		logic [2:0]        bit_index;
		logic [4:0]        bytes_left;
		logic [7:0]        shift_reg;
		logic [2:0]        transfer_kind;
		logic [7:0]        single_byte;
	} seq_state_t;

	function automatic logic is_read_kind(input logic [2:0] k);
		return (k == CMD_READ_REG) || (k == CMD_READ_RAM) || (k == CMD_BURST_READ);
	endfunction

	function automatic logic is_burst_kind(input logic [2:0] k);
		return (k == CMD_BURST_READ) || (k == CMD_BURST_WRITE);
	endfunction

endpackage

/* rtl/core/rtc3w_step.sv */
module rtc3w_step (
	input  rtc3w_pkg::seq_state_t             cur,
	input  rtc3w_pkg::item_t                  item,
	input  logic [rtc3w_pkg::HALF_W-1:0]      half_period,
	output rtc3w_pkg::seq_state_t             nxt,
	output rtc3w_pkg::result_t                res
);
	import rtc3w_pkg::*;

	logic [HALF_W-1:0] delay;
	logic              start;

	// zero delay behaves as one tick
	assign delay = (half_period == '0) ? HALF_W'(1) : half_period;
	assign start = (item.command >= CMD_READ_REG) && (item.command <= CMD_BURST_WRITE);

	// one tick of the sequencer
	always_comb begin
		logic       first;
		logic       seg_end;
		logic       byte_end;
		logic [7:0] addr_byte;
		nxt       = cur;
		res       = '0;
		res.data_drive = 1'b1;
		first     = 1'b0;
		seg_end   = 1'b0;
		byte_end  = 1'b0;
		addr_byte = {2'b00, item.address, 1'b0} & {ADDR_MASK[6:0], 1'b0};

		// start of a transaction
		if (cur.phase == PH_IDLE && start) begin
			nxt.transfer_kind = item.command;
			unique case (item.command)
				CMD_READ_REG:   nxt.shift_reg = addr_byte | CB_READ_REG;
				CMD_WRITE_REG:  nxt.shift_reg = addr_byte | CB_WRITE_REG;
				CMD_READ_RAM:   nxt.shift_reg = addr_byte | CB_READ_RAM;
				CMD_WRITE_RAM:  nxt.shift_reg = addr_byte | CB_WRITE_RAM;
				CMD_BURST_READ: nxt.shift_reg = CB_BURST_READ;
				default:        nxt.shift_reg = CB_BURST_WRITE;
			endcase
			nxt.single_byte = item.write_data;
			nxt.bytes_left  = is_burst_kind(item.command) ? item.burst_length : 5'd1;
			nxt.bit_index   = '0;
			nxt.tick_count  = '0;
			nxt.phase       = PH_SETUP;
		end

		if (nxt.phase == PH_IDLE) begin
			// idle pins
		end else if (nxt.phase == PH_DONE) begin
			res.busy_res   = 1'b1;
			res.done_res   = 1'b1;
			nxt.phase      = PH_IDLE;
			nxt.tick_count = '0;
		end else begin
			res.busy_res    = 1'b1;
			res.chip_enable = 1'b1;
			first = (nxt.tick_count == '0);

			// pin levels and read sampling
			unique case (nxt.phase)
				PH_CMD_HI, PH_WR_HI: begin
					res.serial_clock = 1'b1;
					res.data_out     = nxt.shift_reg[0];
				end
				PH_CMD_LO, PH_WR_LO: begin
					res.data_out = nxt.shift_reg[0];
				end
				PH_TURN, PH_RD_LO: begin
					res.data_drive = 1'b0;
				end
				PH_RD_HI: begin
					res.serial_clock = 1'b1;
					res.data_drive   = 1'b0;
					if (first) begin
						nxt.shift_reg = nxt.shift_reg | (8'(item.data_pin) << nxt.bit_index);
						if (nxt.bit_index == BIT_LAST) begin
							res.read_valid = 1'b1;
							res.read_byte  = nxt.shift_reg;
							res.read_last  = (nxt.bytes_left == '0);
						end
					end
				end
				PH_HOLD: begin
					res.data_drive = !is_read_kind(nxt.transfer_kind);
				end
				default: begin
				end
			endcase

			// delay counter
			seg_end = ({1'b0, nxt.tick_count} + 17'd1) >= {1'b0, delay};
			nxt.tick_count = seg_end ? '0 : nxt.tick_count + HALF_W'(1);

			// phase advance at the end of a delay
			if (seg_end) begin
				byte_end = (nxt.bit_index == BIT_LAST);
				unique case (nxt.phase)
					PH_SETUP: begin
						nxt.bit_index = '0;
						nxt.phase     = PH_CMD_HI;
					end
					PH_CMD_HI: nxt.phase = PH_CMD_LO;
					PH_WR_HI:  nxt.phase = PH_WR_LO;
					PH_RD_HI:  nxt.phase = PH_RD_LO;
					PH_TURN: begin
						nxt.bit_index = '0;
						nxt.phase     = PH_RD_HI;
					end
					PH_HOLD: nxt.phase = PH_DONE;
					PH_CMD_LO, PH_WR_LO, PH_RD_LO: begin
						if (nxt.phase != PH_RD_LO)
							nxt.shift_reg = nxt.shift_reg >> 1;
						nxt.bit_index = nxt.bit_index + 3'd1;
						if (!byte_end) begin
							if (nxt.phase == PH_RD_LO)
								nxt.phase = PH_RD_HI;
							else if (nxt.phase == PH_CMD_LO)
								nxt.phase = PH_CMD_HI;
							else
								nxt.phase = PH_WR_HI;
						end else if (nxt.bytes_left == '0) begin
							nxt.phase = PH_HOLD;
						end else begin
							nxt.bytes_left = nxt.bytes_left - 5'd1;
							nxt.bit_index  = '0;
							if (is_read_kind(nxt.transfer_kind)) begin
								nxt.shift_reg = '0;
								nxt.phase     = PH_TURN;
							end else begin
								if (is_burst_kind(nxt.transfer_kind)) begin
									nxt.shift_reg   = item.write_data;
									res.write_taken = 1'b1;
								end else begin
									nxt.shift_reg = nxt.single_byte;
								end
								nxt.phase = PH_WR_HI;
							end
						end
					end
					default: nxt.phase = PH_IDLE;
				endcase
			end
		end

		// released line reads as low
		if (!res.data_drive)
			res.data_out = 1'b0;
	end

endmodule

/* rtl/core/rtc_three_wire_serial_master.sv */
// Three-wire serial master for a clock/RAM chip (chip enable, serial clock, data).
// Every beat on the item channel is one sequencer tick; a command code 1 to 6 in an
// idle tick starts a transaction. Every item yields exactly one result beat with
// the pin levels for that tick, read bytes, the burst write_taken strobe and
// busy/done flags.
// The cfg channel writes half_period_ticks (ticks per clock half period and per
// setup, turnaround and hold wait); write it only while the block is idle.
// An item is registered in the input register on acceptance, and its result is
// registered in the result register when the pipeline advances.
// Throughput: one item per cycle unless the result receiver stalls; the only loop is
// the one-tick sequencer update between input register and result register.
// Reset clears the sequencer to idle, half_period_ticks to one and both pipeline
// registers to empty.
// When the result receiver stalls, the result register holds, the input register
// fills, and item_ready drops until the result beat is taken.
module rtc_three_wire_serial_master (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtc3w_pkg::HALF_W-1:0]    cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  rtc3w_pkg::item_t                item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output rtc3w_pkg::result_t              result
);
	import rtc3w_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              valid_s2;
	result_t           result_s2;
	seq_state_t        state_q;
	seq_state_t        state_nxt;
	result_t           step_res;
	logic [HALF_W-1:0] half_period_q;
	logic              advance;

	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_W'(1);
		end else if (cfg_valid) begin
			half_period_q <= cfg_data;
		end
	end

	// pipeline handshake
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	rtc3w_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.half_period (half_period_q),
		.nxt         (state_nxt),
		.res         (step_res)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= step_res;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

/* rtl/core/rtc3w_checker.sv */
module rtc3w_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_ready,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  rtc3w_pkg::result_t   result
);
	import rtc3w_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// a full pipeline stays closed while the receiver keeps stalling
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready && !item_ready) ##1 !result_ready |-> !item_ready)
		else $error("item taken while pipeline full");

	// a read byte completes only on a high clock with the line released
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_valid |->
			result.chip_enable && result.serial_clock && !result.data_drive)
		else $error("read byte outside a sampling tick");

	// the done tick has chip enable low and is part of the transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |->
			result.busy_res && !result.chip_enable && !result.serial_clock)
		else $error("bad done tick");

endmodule

bind rtc_three_wire_serial_master rtc3w_checker u_rtc3w_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* dv/rtc_three_wire_serial_master_checker.sv */
`timescale 1ns / 100ps

module rtc_three_wire_serial_master_checker import rtc3w_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [HALF_W-1:0] cfg_data,
	input  logic              item_valid,
	input  logic              item_ready,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result,
	output int                mismatches,
	output int                pending
);

	// shadow copy of the sequencer and its setting
	logic [HALF_W-1:0] half_period;
	logic [3:0]        seq_phase;
	logic [HALF_W-1:0] tick_cnt;
	logic [2:0]        bit_pos;
	logic [4:0]        bytes_remaining;
	logic [7:0]        shifter;
	logic [2:0]        kind;
	logic [7:0]        held_byte;

	result_t expected_ticks[$];
	result_t predicted;
	int      fails;

	function automatic logic is_read_cmd(input logic [2:0] k);
		return k == CMD_READ_REG || k == CMD_READ_RAM || k == CMD_BURST_READ;
	endfunction

	// advance the shadow sequencer by one tick and give the pin levels it drives
	task automatic tick_sequencer(input item_t it, output result_t r);
		logic [HALF_W-1:0] span;
		logic              first;
		logic              seg_end;
		logic              byte_end;
		r = '0;
		r.data_drive = 1'b1;
		span = (half_period == '0) ? HALF_W'(1) : half_period;

		// start a transaction from idle
		if (seq_phase == PH_IDLE && it.command >= CMD_READ_REG &&
				it.command <= CMD_BURST_WRITE) begin
			kind = it.command;
			case (it.command)
				CMD_READ_REG:   shifter = CB_READ_REG | (8'(it.address) << 1);
				CMD_WRITE_REG:  shifter = CB_WRITE_REG | (8'(it.address) << 1);
				CMD_READ_RAM:   shifter = CB_READ_RAM | (8'(it.address) << 1);
				CMD_WRITE_RAM:  shifter = CB_WRITE_RAM | (8'(it.address) << 1);
				CMD_BURST_READ: shifter = CB_BURST_READ;
				default:        shifter = CB_BURST_WRITE;
			endcase
			held_byte = it.write_data;
			if (it.command == CMD_BURST_READ || it.command == CMD_BURST_WRITE) begin
				bytes_remaining = it.burst_length;
			end else begin
				bytes_remaining = 5'd1;
			end
			bit_pos = '0;
			tick_cnt = '0;
			seq_phase = PH_SETUP;
		end

		if (seq_phase == PH_IDLE) begin
		end else if (seq_phase == PH_DONE) begin
			r.busy_res = 1'b1;
			r.done_res = 1'b1;
			seq_phase = PH_IDLE;
			tick_cnt = '0;
		end else begin
			r.busy_res = 1'b1;
			r.chip_enable = 1'b1;
			first = (tick_cnt == '0);

			// pin levels for this phase
			case (seq_phase)
				PH_CMD_HI, PH_WR_HI: begin
					r.serial_clock = 1'b1;
					r.data_out = shifter[0];
				end
				PH_CMD_LO, PH_WR_LO: r.data_out = shifter[0];
				PH_TURN, PH_RD_LO:   r.data_drive = 1'b0;
				PH_RD_HI: begin
					r.serial_clock = 1'b1;
					r.data_drive = 1'b0;
					if (first) begin
						shifter = shifter | (8'(it.data_pin) << bit_pos);
						if (bit_pos == BIT_LAST) begin
							r.read_valid = 1'b1;
							r.read_byte = shifter;
							r.read_last = (bytes_remaining == '0);
						end
					end
				end
				PH_HOLD: r.data_drive = !is_read_cmd(kind);
				default: ;
			endcase

			// delay counter and phase change at the end of a delay
			seg_end = ({1'b0, tick_cnt} + 17'd1) >= {1'b0, span};
			tick_cnt = seg_end ? '0 : tick_cnt + HALF_W'(1);
			if (seg_end) begin
				byte_end = (bit_pos == BIT_LAST);
				case (seq_phase)
					PH_SETUP: begin
						bit_pos = '0;
						seq_phase = PH_CMD_HI;
					end
					PH_CMD_HI: seq_phase = PH_CMD_LO;
					PH_WR_HI:  seq_phase = PH_WR_LO;
					PH_RD_HI:  seq_phase = PH_RD_LO;
					PH_TURN: begin
						bit_pos = '0;
						seq_phase = PH_RD_HI;
					end
					PH_HOLD: seq_phase = PH_DONE;
					PH_CMD_LO, PH_WR_LO, PH_RD_LO: begin
						if (seq_phase != PH_RD_LO) begin
							shifter = shifter >> 1;
						end
						bit_pos = bit_pos + 3'd1;
						if (!byte_end) begin
							if (seq_phase == PH_RD_LO) begin
								seq_phase = PH_RD_HI;
							end else if (seq_phase == PH_CMD_LO) begin
								seq_phase = PH_CMD_HI;
							end else begin
								seq_phase = PH_WR_HI;
							end
						end else if (bytes_remaining == '0) begin
							seq_phase = PH_HOLD;
						end else begin
							bytes_remaining = bytes_remaining - 5'd1;
							bit_pos = '0;
							if (is_read_cmd(kind)) begin
								shifter = '0;
								seq_phase = PH_TURN;
							end else begin
								if (kind == CMD_BURST_READ || kind == CMD_BURST_WRITE) begin
									shifter = it.write_data;
									r.write_taken = 1'b1;
								end else begin
									shifter = held_byte;
								end
								seq_phase = PH_WR_HI;
							end
						end
					end
					default: seq_phase = PH_IDLE;
				endcase
			end
		end

		if (!r.data_drive) begin
			r.data_out = 1'b0;
		end
	endtask

	task automatic report_field(input string name, input int exp, input int act);
		fails++;
		if (fails <= 10) begin
			$display("mismatch on %s: expected %0h, got %0h", name, exp, act);
		end
	endtask

	task automatic check_beat(input result_t exp, input result_t got);
		if (exp.chip_enable !== got.chip_enable)
			report_field("chip_enable", exp.chip_enable, got.chip_enable);
		if (exp.serial_clock !== got.serial_clock)
			report_field("serial_clock", exp.serial_clock, got.serial_clock);
		if (exp.data_out !== got.data_out)
			report_field("data_out", exp.data_out, got.data_out);
		if (exp.data_drive !== got.data_drive)
			report_field("data_drive", exp.data_drive, got.data_drive);
		if (exp.read_byte !== got.read_byte)
			report_field("read_byte", exp.read_byte, got.read_byte);
		if (exp.read_valid !== got.read_valid)
			report_field("read_valid", exp.read_valid, got.read_valid);
		if (exp.read_last !== got.read_last)
			report_field("read_last", exp.read_last, got.read_last);
		if (exp.write_taken !== got.write_taken)
			report_field("write_taken", exp.write_taken, got.write_taken);
		if (exp.busy_res !== got.busy_res)
			report_field("busy_res", exp.busy_res, got.busy_res);
		if (exp.done_res !== got.done_res)
			report_field("done_res", exp.done_res, got.done_res);
	endtask

	// watch the three channels, predict on item beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period = HALF_W'(1);
			seq_phase = PH_IDLE;
			tick_cnt = '0;
			bit_pos = '0;
			bytes_remaining = '0;
			shifter = '0;
			kind = CMD_NONE;
			held_byte = '0;
			expected_ticks.delete();
			fails = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_period = cfg_data;
			end
			if (item_valid && item_ready) begin
				tick_sequencer(item, predicted);
				expected_ticks.push_back(predicted);
			end
			if (result_valid && result_ready) begin
				if (expected_ticks.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("result beat %h with nothing expected", result);
					end
				end else begin
					check_beat(expected_ticks.pop_front(), result);
				end
			end
			mismatches <= fails;
			pending <= expected_ticks.size();
		end
	end

endmodule

/* dv/tb_rtc_three_wire_serial_master.sv */
`timescale 1ns / 100ps

module tb_rtc_three_wire_serial_master;
	import rtc3w_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PIN_LOW       = 0;
	localparam int PIN_HIGH      = 1;
	localparam int PIN_RANDOM    = 2;
	localparam int NUM_PHASES    = 9;

	// random phases: delay setting, sender idle and receiver stall percentages, ticks
	int phase_half [NUM_PHASES] = '{2, 0, 1, 3, 65535, 1, 5, 1, 2};
	int phase_idle [NUM_PHASES] = '{0, 58, 0, 27, 58, 27, 0, 0, 58};
	int phase_stall[NUM_PHASES] = '{0, 0, 58, 27, 0, 27, 0, 58, 58};
	int phase_ticks[NUM_PHASES] = '{80, 80, 90, 80, 40, 90, 80, 80, 80};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [HALF_W-1:0] cfg_data = '0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	item_t             item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;

	int   mismatches;
	int   pending;
	int   send_idle = 0;
	int   recv_stall = 0;
	logic last_done = 1'b0;
	int   quiet_cycles = 0;

	rtc_three_wire_serial_master uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	rtc_three_wire_serial_master_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// done flag of the most recent result beat
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			last_done <= result.done_res;
		end
	end

	// watchdog on cycles without any beat
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(item_valid && item_ready) && !(result_valid && result_ready) &&
					!(cfg_valid && cfg_ready)) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
		end
		$display("tb_rtc_three_wire_serial_master NOT OK");
		$finish;
	end

	// one tick beat, after a random gap
	task automatic send_tick(input item_t t);
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= t;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// one tick beat, then wait for its result
	task automatic tick_and_wait(input item_t t);
		send_tick(t);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_half_period(input logic [HALF_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain all results, let the pipeline settle, then change the delay
	task automatic reconfigure(input logic [HALF_W-1:0] v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_half_period(v);
	endtask

	// one whole transaction in lockstep, until its done tick comes back
	task automatic run_transfer(input logic [2:0] cmd, input logic [4:0] addr,
			input logic [7:0] data, input logic [4:0] len, input int pins,
			input logic noisy);
		item_t t;
		t.command = cmd;
		t.address = addr;
		t.write_data = data;
		t.burst_length = len;
		t.data_pin = (pins == PIN_HIGH);
		tick_and_wait(t);
		while (!last_done) begin
			t.command = noisy ? 3'($urandom_range(1, 7)) : CMD_NONE;
			t.address = 5'($urandom);
			t.write_data = 8'($urandom);
			t.burst_length = 5'($urandom);
			t.data_pin = (pins == PIN_RANDOM) ? 1'($urandom) : (pins == PIN_HIGH);
			tick_and_wait(t);
		end
	endtask

	// mostly quiet ticks with occasional starts, mostly short bursts
	function automatic item_t random_tick();
		item_t t;
		t.command = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
		t.address = 5'($urandom);
		t.write_data = 8'($urandom);
		t.burst_length = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
		t.data_pin = 1'($urandom);
		return t;
	endfunction

	initial begin
		item_t t;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transfers at the shortest delay
		write_half_period(HALF_W'(1));
		run_transfer(CMD_READ_REG, 5'd0, 8'h00, 5'd0, PIN_HIGH, 1'b0);
		run_transfer(CMD_WRITE_REG, 5'd31, 8'hff, 5'd31, PIN_RANDOM, 1'b0);
		run_transfer(CMD_READ_RAM, 5'd31, 8'h00, 5'd0, PIN_LOW, 1'b1);
		run_transfer(CMD_WRITE_RAM, 5'd0, 8'h00, 5'd0, PIN_RANDOM, 1'b1);
		run_transfer(CMD_BURST_READ, 5'd0, 8'h00, 5'd0, PIN_RANDOM, 1'b0);
		run_transfer(CMD_BURST_WRITE, 5'd0, 8'h00, 5'd0, PIN_RANDOM, 1'b0);
		run_transfer(CMD_BURST_READ, 5'd31, 8'hff, 5'd2, PIN_RANDOM, 1'b1);
		run_transfer(CMD_BURST_WRITE, 5'd31, 8'h5a, 5'd3, PIN_RANDOM, 1'b0);
		run_transfer(CMD_BURST_READ, 5'd7, 8'h00, 5'd31, PIN_HIGH, 1'b0);
		run_transfer(CMD_BURST_WRITE, 5'd0, 8'hff, 5'd4, PIN_RANDOM, 1'b1);

		// unused command code in idle does nothing
		t = '0;
		t.command = CMD_UNUSED;
		t.address = 5'd31;
		t.write_data = 8'hff;
		t.burst_length = 5'd31;
		t.data_pin = 1'b1;
		tick_and_wait(t);

		// zero delay behaves as one
		reconfigure('0);
		run_transfer(CMD_READ_RAM, 5'd21, 8'h00, 5'd0, PIN_RANDOM, 1'b0);
		run_transfer(CMD_WRITE_REG, 5'd10, 8'ha5, 5'd0, PIN_RANDOM, 1'b1);

		// random phases with varying delay and idling
		for (int p = 0; p < NUM_PHASES; p++) begin
			reconfigure(HALF_W'(phase_half[p]));
			send_idle = phase_idle[p];
			recv_stall <= phase_stall[p];
			for (int i = 0; i < phase_ticks[p]; i++) begin
				send_tick(random_tick());
			end
		end

		// wait for the last results
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_rtc_three_wire_serial_master OK");
		end else begin
			$display("tb_rtc_three_wire_serial_master NOT OK");
		end
		$finish;
	end

endmodule
